/* sv/motor_stall_overcurrent_detector_unit_assert.svh */
// Assertion helpers for the stall/overcurrent detector.
// Every check is clocked on aclk and held off while aresetn is low.
`ifndef MOTOR_STALL_OVERCURRENT_DETECTOR_UNIT_ASSERT_SVH
`define MOTOR_STALL_OVERCURRENT_DETECTOR_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define MSOD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("msod assertion failed: same-cycle implication");

// Check that the consequent holds in the cycle after the antecedent.
`define MSOD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("msod assertion failed: next-cycle implication");

`endif

/* sv/msod_pkg.sv */
package msod_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CfgAddrW = 3;
    typedef enum logic [CfgAddrW-1:0] {
        REG_WARN_THRESHOLD = 3'd0,
        REG_TRIP_THRESHOLD = 3'd1,
        REG_SUSTAIN_LIMIT  = 3'd2,
        REG_TRIP_LIMIT     = 3'd3,
        REG_RECOVER_LIMIT  = 3'd4,
        REG_DETECT_ENABLE  = 3'd5
    } cfg_reg_t;

    localparam int unsigned CurW   = 16;
    localparam int unsigned CountW = 8;

    // Power-on register values (first motor type)
    localparam logic [CurW-1:0]   WarnThresholdRst = 16'd450;
    localparam logic [CurW-1:0]   TripThresholdRst = 16'd550;
    localparam logic [CountW-1:0] SustainLimitRst  = 8'd200;
    localparam logic [CountW-1:0] TripLimitRst     = 8'd2;
    localparam logic [CountW-1:0] RecoverLimitRst  = 8'd5;
    localparam logic              DetectEnableRst  = 1'b1;

    // Live register settings handed to the detector core
    typedef struct packed {
        logic [CurW-1:0]   warn_threshold;
        logic [CurW-1:0]   trip_threshold;
        logic [CountW-1:0] sustain_limit;
        logic [CountW-1:0] trip_limit;
        logic [CountW-1:0] recover_limit;
        logic              detect_enable;
    } msod_cfg_t;

    // One result item
    typedef struct packed {
        logic warn_event;
        logic stall_flag;
    } msod_result_t;

endpackage

/* sv/msod_core.sv */
module msod_core
    import msod_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  msod_cfg_t         cfg,
    input  logic              item_accept,
    input  logic              motor_active,
    input  logic [CurW-1:0]   current_sample,
    output msod_result_t      result
);

    logic [CountW-1:0] sustain_count_reg, sustain_count_next;
    logic [CountW-1:0] trip_count_reg, trip_count_next;
    logic [CountW-1:0] recover_count_reg, recover_count_next;
    logic              stall_latch_reg, stall_latch_next;

    logic              in_warn_band;
    logic              over_trip;
    logic [CountW-1:0] sustain_inc;
    logic [CountW-1:0] trip_inc;
    logic [CountW-1:0] recover_inc;
    logic              event_now;

    // Classify the sample against the band edges
    assign in_warn_band = (current_sample >= cfg.warn_threshold) &&
                          (current_sample <  cfg.trip_threshold);
    assign over_trip    = (current_sample >= cfg.trip_threshold);

    assign sustain_inc = sustain_count_reg + CountW'(1);
    assign trip_inc    = trip_count_reg + CountW'(1);
    assign recover_inc = recover_count_reg + CountW'(1);

    // Update counters and stall latch for the current sample
    always_comb begin
        sustain_count_next = sustain_count_reg;
        trip_count_next    = trip_count_reg;
        recover_count_next = recover_count_reg;
        stall_latch_next   = stall_latch_reg;
        event_now          = 1'b0;
        if (!motor_active) begin
            sustain_count_next = '0;
            trip_count_next    = '0;
            recover_count_next = '0;
            stall_latch_next   = 1'b0;
        end else if (cfg.detect_enable) begin
            if (in_warn_band) begin
                recover_count_next = '0;
                sustain_count_next = sustain_inc;
                if (sustain_inc >= cfg.sustain_limit) begin
                    sustain_count_next = '0;
                    stall_latch_next   = 1'b1;
                    event_now          = 1'b1;
                end
            end else if (over_trip) begin
                recover_count_next = '0;
                trip_count_next    = trip_inc;
                if (trip_inc >= cfg.trip_limit) begin
                    trip_count_next  = '0;
                    stall_latch_next = 1'b1;
                    event_now        = 1'b1;
                end
            end else begin
                recover_count_next = recover_inc;
                if (recover_inc >= cfg.recover_limit) begin
                    recover_count_next = '0;
                    trip_count_next    = '0;
                    sustain_count_next = '0;
                end
            end
        end
    end

    assign result.stall_flag = stall_latch_next;
    assign result.warn_event = event_now;

    // Advance state only on an accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sustain_count_reg <= '0;
            trip_count_reg    <= '0;
            recover_count_reg <= '0;
            stall_latch_reg   <= 1'b0;
        end else if (item_accept) begin
            sustain_count_reg <= sustain_count_next;
            trip_count_reg    <= trip_count_next;
            recover_count_reg <= recover_count_next;
            stall_latch_reg   <= stall_latch_next;
        end
    end

endmodule

/* sv/motor_stall_overcurrent_detector_unit.sv */
// A result goes to the output register when its sample is accepted, or to the
// skid entry if the output is held. One sample per cycle while s_tready is high;
// the counter compare/increment path settles within the cycle, and a two-entry
// output buffer keeps s_tready high for one extra request while m_tready is low.
// Reset (aresetn low, synchronous): counters and stall latch clear, the
// output buffer empties and the registers return to 450/550/200/2/5/enabled.
module motor_stall_overcurrent_detector_unit
    import msod_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_wr_en,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CurW-1:0]     cfg_wr_data,
    // input samples
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // [0] motor_active, [16:1] current_sample
    // results
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata    // [0] stall_flag, [1] warn_event
);

    msod_cfg_t    cfg_reg;
    msod_result_t result;
    msod_result_t out_data_reg;
    msod_result_t skid_data_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         s_accept;
    logic         out_free;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warn_threshold <= WarnThresholdRst;
            cfg_reg.trip_threshold <= TripThresholdRst;
            cfg_reg.sustain_limit  <= SustainLimitRst;
            cfg_reg.trip_limit     <= TripLimitRst;
            cfg_reg.recover_limit  <= RecoverLimitRst;
            cfg_reg.detect_enable  <= DetectEnableRst;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WARN_THRESHOLD: cfg_reg.warn_threshold <= cfg_wr_data;
                REG_TRIP_THRESHOLD: cfg_reg.trip_threshold <= cfg_wr_data;
                REG_SUSTAIN_LIMIT:  cfg_reg.sustain_limit  <= cfg_wr_data[CountW-1:0];
                REG_TRIP_LIMIT:     cfg_reg.trip_limit     <= cfg_wr_data[CountW-1:0];
                REG_RECOVER_LIMIT:  cfg_reg.recover_limit  <= cfg_wr_data[CountW-1:0];
                REG_DETECT_ENABLE:  cfg_reg.detect_enable  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    msod_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .item_accept    (s_accept),
        .motor_active   (s_tdata[0]),
        .current_sample (s_tdata[16:1]),
        .result         (result)
    );

    // Hold results in the output register, spill to the skid entry on a stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (s_accept) begin
                out_data_reg <= result;
            end
        end else if (s_accept) begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_data_reg.warn_event, out_data_reg.stall_flag};

`include "motor_stall_overcurrent_detector_unit_assert.svh"

    // skid entry only fills behind a held result
    `MSOD_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // a warning event always comes with the stall flag set
    `MSOD_ASSERT_SAME(a_event_sets_stall, m_tvalid && m_tdata[1], m_tdata[0])
    // an accepted request always shows up as a pending result
    `MSOD_ASSERT_NEXT(a_accept_to_output, s_accept, out_valid_reg)

endmodule
